// File: rtl/fbpa_pkg.sv
// Shared types and constants for the fixed block pool allocator.
// No dependencies; used by fbpa_engine and the top level in rtl/.
`timescale 1ns / 1ps
`default_nettype none
package fbpa_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_REINIT = 2'd3
  } req_t;

  // result status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_BLOCK  = 3'd1;
  localparam logic [2:0] ST_OUTSIDE   = 3'd2;
  localparam logic [2:0] ST_MISALIGN  = 3'd3;
  localparam logic [2:0] ST_DBL_FREE  = 3'd4;

  localparam int DESC_W   = 54;
  localparam int NREG     = 4;
  localparam int REG_IDX_W = 2;
  localparam int BMAP_W   = 32;
  localparam int FCNT_W   = 6;

  // one queued request between front and back
  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] size;
    logic [31:0] addr;
  } req_item_t;

  // one result item
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] block_addr;
    logic [1:0]  pool_index;
    logic [5:0]  free_count;
  } rsp_item_t;

  // back-end engine states
  typedef enum logic [2:0] {
    S_IDLE,
    S_ALLOC,
    S_FREE_SCAN,
    S_DIV,
    S_DONE
  } eng_state_t;

endpackage
`default_nettype wire

// File: rtl/fbpa_fifo.sv
// Small register queue carrying items between allocator stages.
// Depends on nothing but its parameters.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_fifo #(
  parameter int WIDTH = 50,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic [WIDTH-1:0]      rdata,
  output logic                  empty
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rp_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + CW'(do_push) - CW'(do_pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= wdata;
  end
endmodule
`default_nettype wire

// File: rtl/fbpa_engine.sv
// Back end: pool descriptors, free bitmaps, and the request engine with
// its serial divider. Depends on fbpa_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fbpa_engine #(
  parameter int POOLS = 4,
  parameter int BLOCKS_PER_POOL = 32,
  parameter int ALIGNMENT = 8,
  parameter int ADDR_BITS = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        cfg_we,
  input  wire logic [fbpa_pkg::REG_IDX_W-1:0] cfg_idx,
  input  wire logic [fbpa_pkg::DESC_W-1:0] cfg_val,
  input  wire logic                        req_vld,
  input  wire fbpa_pkg::req_item_t         req,
  output logic                             req_take,
  output logic                             rsp_vld,
  output fbpa_pkg::rsp_item_t              rsp,
  input  wire logic                        rsp_full,
  output logic                             idle
);
  import fbpa_pkg::*;

  localparam int QB = 32;   // quotient bits for offset / block size

  logic [DESC_W-1:0] desc_r [NREG];
  logic [BMAP_W-1:0] bmap_r [NREG];

  // per-pool decoded fields
  logic [31:0] base   [NREG];
  logic [16:0] psize  [NREG];
  logic [5:0]  pcnt   [NREG];
  logic        pon    [NREG];
  logic [BMAP_W-1:0] fmask [NREG];

  function automatic logic [16:0] round_up(input logic [15:0] v);
    logic [16:0] s;
    s = 17'(v) + 17'(ALIGNMENT - 1);
    return (s / 17'(ALIGNMENT)) * 17'(ALIGNMENT);
  endfunction

  always_comb begin
    for (int p = 0; p < NREG; p++) begin
      base[p]  = desc_r[p][31:0];
      psize[p] = round_up(desc_r[p][47:32]);
      pcnt[p]  = (desc_r[p][53:48] > 6'(BLOCKS_PER_POOL)) ? 6'(BLOCKS_PER_POOL)
                                                           : desc_r[p][53:48];
      pon[p]   = (p < POOLS) && (pcnt[p] != '0) && (psize[p] != '0);
      fmask[p] = '0;
      if (pon[p]) begin
        for (int b = 0; b < BMAP_W; b++) fmask[p][b] = (6'(b) < pcnt[p]);
      end
    end
  end

  // full mask of the descriptor being written
  logic [16:0] cfg_psize;
  logic [5:0]  cfg_pcnt;
  logic [BMAP_W-1:0] cfg_mask;
  always_comb begin
    cfg_psize = round_up(cfg_val[47:32]);
    cfg_pcnt  = (cfg_val[53:48] > 6'(BLOCKS_PER_POOL)) ? 6'(BLOCKS_PER_POOL)
                                                        : cfg_val[53:48];
    cfg_mask  = '0;
    if ((int'(cfg_idx) < POOLS) && (cfg_pcnt != '0) && (cfg_psize != '0)) begin
      for (int b = 0; b < BMAP_W; b++) cfg_mask[b] = (6'(b) < cfg_pcnt);
    end
  end

  eng_state_t state_r, state_nxt;
  req_item_t  cur_r;
  logic [NREG-1:0] tried_r, tried_nxt;
  logic [1:0]  pool_r, pool_nxt;
  logic [5:0]  step_r, step_nxt;
  logic [31:0] rem_r, rem_nxt, quo_r, quo_nxt;
  rsp_item_t   res_r, res_nxt;
  logic        bm_we;
  logic [1:0]  bm_idx;
  logic [BMAP_W-1:0] bm_val;
  logic        reinit;

  // alloc candidate selection: smallest untried fitting pool
  logic        cand_ok;
  logic [1:0]  cand;
  always_comb begin
    cand_ok = 1'b0;
    cand    = '0;
    for (int p = 0; p < NREG; p++) begin
      if (!tried_r[p] && pon[p] && psize[p] >= 17'(cur_r.size)) begin
        if (!cand_ok || psize[p] < psize[cand]) begin
          cand_ok = 1'b1;
          cand    = 2'(p);
        end
      end
    end
  end

  // lowest free bit of candidate
  logic [4:0] low_idx;
  always_comb begin
    low_idx = '0;
    for (int b = BMAP_W - 1; b >= 0; b--) if (bmap_r[cand][b]) low_idx = 5'(b);
  end

  // free: first pool containing the address
  logic        hit_ok;
  logic [1:0]  hit;
  logic [39:0] pend [NREG];
  always_comb begin
    hit_ok = 1'b0;
    hit    = '0;
    for (int p = NREG - 1; p >= 0; p--) begin
      pend[p] = 40'(base[p]) + 40'(psize[p]) * 40'(pcnt[p]);
      if (pon[p] && cur_r.addr >= base[p] && 40'(cur_r.addr) < pend[p]) begin
        hit_ok = 1'b1;
        hit    = 2'(p);
      end
    end
  end

  // query: first pool of exact size, popcount of its bitmap
  logic        q_ok;
  logic [1:0]  q_idx;
  logic [5:0]  q_cnt;
  always_comb begin
    q_ok  = 1'b0;
    q_idx = '0;
    for (int p = NREG - 1; p >= 0; p--) begin
      if (pon[p] && psize[p] == round_up(cur_r.size)) begin
        q_ok  = 1'b1;
        q_idx = 2'(p);
      end
    end
    q_cnt = '0;
    for (int b = 0; b < BMAP_W; b++) q_cnt = q_cnt + 6'(bmap_r[q_idx][b]);
  end

  // restoring divider step
  logic [32:0] trial;
  assign trial = {rem_r, quo_r[31]} - 33'(psize[pool_r]);

  // block index times block size fits in 22 bits
  logic [21:0] prod;
  assign prod = 22'(low_idx) * 22'(psize[cand]);

  // control
  always_comb begin
    state_nxt = state_r;
    tried_nxt = tried_r;
    pool_nxt  = pool_r;
    step_nxt  = step_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    res_nxt   = res_r;
    req_take  = 1'b0;
    bm_we     = 1'b0;
    bm_idx    = cand;
    bm_val    = '0;
    reinit    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (req_vld) begin
          req_take  = 1'b1;
          tried_nxt = '0;
          res_nxt   = '0;
          case (req.kind)
            REQ_ALLOC: state_nxt = S_ALLOC;
            REQ_FREE:  state_nxt = S_FREE_SCAN;
            default:   state_nxt = S_DONE;
          endcase
          if (req.kind == REQ_QUERY || req.kind == REQ_REINIT) state_nxt = S_FREE_SCAN;
        end
      end
      S_ALLOC: begin
        if (!cand_ok) begin
          res_nxt.status = ST_NO_BLOCK;
          state_nxt = S_DONE;
        end else if (bmap_r[cand] == '0) begin
          tried_nxt[cand] = 1'b1;
        end else begin
          bm_we  = 1'b1;
          bm_val = bmap_r[cand] & ~(BMAP_W'(1) << low_idx);
          res_nxt.status     = ST_OK;
          res_nxt.block_addr = 32'((64'(base[cand]) + 64'(prod))
                               & ((64'(1) << ADDR_BITS) - 64'(1)));
          res_nxt.pool_index = cand;
          state_nxt = S_DONE;
        end
      end
      S_FREE_SCAN: begin
        if (cur_r.kind == REQ_QUERY) begin
          res_nxt.pool_index = q_ok ? q_idx : 2'd0;
          res_nxt.free_count = q_ok ? q_cnt : 6'd0;
          state_nxt = S_DONE;
        end else if (cur_r.kind == REQ_REINIT) begin
          reinit    = 1'b1;
          state_nxt = S_DONE;
        end else if (!hit_ok) begin
          res_nxt.status = ST_OUTSIDE;
          state_nxt = S_DONE;
        end else begin
          pool_nxt = hit;
          res_nxt.pool_index = hit;
          rem_nxt  = '0;
          quo_nxt  = cur_r.addr - base[hit];
          step_nxt = '0;
          state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (step_r == 6'(QB)) begin
          bm_idx = pool_r;
          if (rem_r != '0) res_nxt.status = ST_MISALIGN;
          else if (bmap_r[pool_r][quo_r[4:0]]) res_nxt.status = ST_DBL_FREE;
          else begin
            bm_we  = 1'b1;
            bm_val = bmap_r[pool_r] | (BMAP_W'(1) << quo_r[4:0]);
            res_nxt.status = ST_OK;
          end
          state_nxt = S_DONE;
        end else begin
          if (!trial[32]) begin
            rem_nxt = trial[31:0];
            quo_nxt = {quo_r[30:0], 1'b1};
          end else begin
            rem_nxt = {rem_r[30:0], quo_r[31]};
            quo_nxt = {quo_r[30:0], 1'b0};
          end
          step_nxt = step_r + 6'd1;
        end
      end
      S_DONE: begin
        if (!rsp_full) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign rsp_vld = (state_r == S_DONE) && !rsp_full;
  assign rsp     = res_r;
  assign idle    = (state_r == S_IDLE);

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (req_take) cur_r <= req;
    tried_r <= tried_nxt;
    pool_r  <= pool_nxt;
    step_r  <= step_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    res_r   <= res_nxt;
  end

  // descriptors and bitmaps; a written descriptor reloads its own bitmap
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int p = 0; p < NREG; p++) begin
        desc_r[p] <= '0;
        bmap_r[p] <= '0;
      end
    end else if (cfg_we) begin
      desc_r[cfg_idx] <= cfg_val;
      bmap_r[cfg_idx] <= cfg_mask;
    end else if (reinit) begin
      for (int p = 0; p < NREG; p++) bmap_r[p] <= fmask[p];
    end else if (bm_we) begin
      bmap_r[bm_idx] <= bm_val;
    end
  end
endmodule
`default_nettype wire

// File: rtl/fixed_block_pool_allocator.sv
// Top level of the fixed block pool allocator: config port, request and
// result queues around fbpa_engine. Depends on fbpa_pkg, fbpa_fifo, fbpa_engine.
`timescale 1ns / 1ps
`default_nettype none
// Allocator for up to four fixed-size block pools. Requests enter a two-entry
// queue and are executed one at a time by the back end; results leave through
// a two-entry queue. Allocate tries pools in turn, smallest fitting size first,
// until one has a free block or none is left; free splits the pool offset by
// the block size in a 32-step serial divider.
// Descriptor writes are taken only while no request is in flight.
module fixed_block_pool_allocator #(
  parameter int POOLS = 4,
  parameter int BLOCKS_PER_POOL = 32,
  parameter int ALIGNMENT = 8,
  parameter int ADDR_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_push,
  output logic             in_full,
  input  wire logic [1:0]  in_req_type,
  input  wire logic [15:0] in_req_size,
  input  wire logic [31:0] in_req_addr,
  output logic             out_empty,
  input  wire logic        out_pop,
  output logic [2:0]       out_status,
  output logic [31:0]      out_block_addr,
  output logic [1:0]       out_pool_index,
  output logic [5:0]       out_free_count,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [53:0] cfg_data
);
  import fbpa_pkg::*;

  req_item_t in_item, q_item;
  rsp_item_t eng_rsp, out_item;
  logic q_empty, q_take, rsp_vld, rsp_full, eng_idle;

  assign in_item = '{kind: in_req_type, size: in_req_size, addr: in_req_addr};
  // config only while no request is queued or executing
  assign cfg_ready = q_empty && eng_idle;

  // request queue
  fbpa_fifo #(.WIDTH($bits(req_item_t)), .DEPTH(2)) u_req_q (
    .clk, .rst_n, .push(in_push), .wdata(in_item), .full(in_full),
    .pop(q_take), .rdata(q_item), .empty(q_empty)
  );

  // execution back end
  fbpa_engine #(.POOLS(POOLS), .BLOCKS_PER_POOL(BLOCKS_PER_POOL),
                .ALIGNMENT(ALIGNMENT), .ADDR_BITS(ADDR_BITS)) u_eng (
    .clk, .rst_n, .cfg_we(cfg_valid && cfg_ready), .cfg_idx(cfg_index),
    .cfg_val(cfg_data),
    .req_vld(!q_empty), .req(q_item), .req_take(q_take),
    .rsp_vld, .rsp(eng_rsp), .rsp_full, .idle(eng_idle)
  );

  // result queue
  fbpa_fifo #(.WIDTH($bits(rsp_item_t)), .DEPTH(2)) u_rsp_q (
    .clk, .rst_n, .push(rsp_vld), .wdata(eng_rsp), .full(rsp_full),
    .pop(out_pop), .rdata(out_item), .empty(out_empty)
  );

  assign out_status     = out_item.status;
  assign out_block_addr = out_item.block_addr;
  assign out_pool_index = out_item.pool_index;
  assign out_free_count = out_item.free_count;

  // checks
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_status <= ST_DBL_FREE) else $error("bad status");
  a_addr_ok_only: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_status != ST_OK) |-> out_block_addr == '0)
    else $error("address on failed result");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> out_free_count <= 6'(BLOCKS_PER_POOL)) else $error("count range");
endmodule
`default_nettype wire
